@@ design/utf16_to_utf8_encoder_top_assert.svh @@
// Assertion macros shared by the encoder modules.
`ifndef UTF16_TO_UTF8_ENCODER_TOP_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define U8E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define U8E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/utf8e_pkg.sv @@
package utf8e_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam int unsigned MaxBytes  = 6;
  localparam int unsigned ByteCntW  = 3;

  localparam logic [5:0]  HighSurrTag  = 6'b110110;
  localparam logic [5:0]  LowSurrTag   = 6'b110111;
  localparam logic [20:0] SuppBase     = 21'h10000;
  localparam logic [20:0] OneByteMax   = 21'h7F;
  localparam logic [20:0] TwoByteMax   = 21'h7FF;
  localparam logic [20:0] ThreeByteMax = 21'hFFFF;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  // Bytes of one encoded scalar value, first byte at index 0.
  typedef struct packed {
    logic [3:0][7:0]     b;
    logic [ByteCntW-1:0] n;
  } enc_t;

  // Bytes caused by one input item, first byte at index 0.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [ByteCntW-1:0]      cnt;
  } seq_t;

  function automatic enc_t encode(logic [20:0] c);
    enc_t e;
    e.b = '0;
    if (c <= OneByteMax) begin
      e.b[0] = c[7:0];
      e.n    = ByteCntW'(1);
    end else if (c <= TwoByteMax) begin
      e.b[0] = {3'b110, c[10:6]};
      e.b[1] = {2'b10, c[5:0]};
      e.n    = ByteCntW'(2);
    end else if (c <= ThreeByteMax) begin
      e.b[0] = {4'b1110, c[15:12]};
      e.b[1] = {2'b10, c[11:6]};
      e.b[2] = {2'b10, c[5:0]};
      e.n    = ByteCntW'(3);
    end else begin
      e.b[0] = {5'b11110, c[20:18]};
      e.b[1] = {2'b10, c[17:12]};
      e.b[2] = {2'b10, c[11:6]};
      e.b[3] = {2'b10, c[5:0]};
      e.n    = ByteCntW'(4);
    end
    return e;
  endfunction

endpackage

@@ design/utf8e_front.sv @@
module utf8e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  utf8e_pkg::in_t   item_i,
  output logic             seq_push_o,
  output utf8e_pkg::seq_t  seq_o
);

  logic       held_q, held_d;
  logic [9:0] hbits_q, hbits_d;

  logic            is_high, is_low, hold_new;
  utf8e_pkg::enc_t enc_held, enc_pair, enc_unit;

  assign is_high  = item_i.code_unit[15:10] == utf8e_pkg::HighSurrTag;
  assign is_low   = item_i.code_unit[15:10] == utf8e_pkg::LowSurrTag;
  assign hold_new = is_high && !item_i.string_last;

  assign enc_held = utf8e_pkg::encode({5'b0, utf8e_pkg::HighSurrTag, hbits_q});
  assign enc_pair = utf8e_pkg::encode(utf8e_pkg::SuppBase +
                                      {1'b0, hbits_q, item_i.code_unit[9:0]});
  assign enc_unit = utf8e_pkg::encode({5'b0, item_i.code_unit});

  always_comb begin
    seq_o = '0;
    if (held_q && is_low) begin
      seq_o.bytes[3:0] = enc_pair.b;
      seq_o.cnt        = enc_pair.n;
    end else if (held_q) begin
      // Flush the lone held surrogate, then append the new unit behind it unless that unit is held in turn.
      seq_o.bytes[2:0] = enc_held.b[2:0];
      seq_o.cnt        = enc_held.n;
      if (!hold_new) begin
        seq_o.bytes[5:3] = enc_unit.b[2:0];
        seq_o.cnt        = enc_held.n + enc_unit.n;
      end
    end else if (!hold_new) begin
      seq_o.bytes[3:0] = enc_unit.b;
      seq_o.cnt        = enc_unit.n;
    end
  end

  assign seq_push_o = accept_i && (seq_o.cnt != '0);

  always_comb begin
    held_d  = held_q;
    hbits_d = hbits_q;
    if (accept_i) begin
      held_d  = hold_new;
      hbits_d = hold_new ? item_i.code_unit[9:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      hbits_q <= '0;
    end else begin
      held_q  <= held_d;
      hbits_q <= hbits_d;
    end
  end

`include "utf16_to_utf8_encoder_top_assert.svh"

  `U8E_ASSERT_NEXT(a_last_clears_hold, accept_i && item_i.string_last, !held_q, "surrogate held after last unit")
  `U8E_ASSERT_NEXT(a_hold_quiet, accept_i && hold_new && !held_q, !$past(seq_push_o), "held surrogate pushed bytes")

endmodule

@@ design/utf8e_fifo.sv @@
module utf8e_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8e_pkg::seq_t  wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output utf8e_pkg::seq_t  rdata_o,
  output logic             empty_o
);

  utf8e_pkg::seq_t                     mem_q [utf8e_pkg::FifoDepth];
  logic [utf8e_pkg::PtrW-1:0]          wptr_q, wptr_d, rptr_q, rptr_d;
  logic [utf8e_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign full_o  = cnt_q == utf8e_pkg::CntW'(utf8e_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == utf8e_pkg::PtrW'(utf8e_pkg::FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == utf8e_pkg::PtrW'(utf8e_pkg::FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`include "utf16_to_utf8_encoder_top_assert.svh"

  `U8E_ASSERT(a_fifo_cnt_range, cnt_q <= utf8e_pkg::CntW'(utf8e_pkg::FifoDepth), "fifo count overflow")

endmodule

@@ design/utf8e_back.sv @@
module utf8e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utf8e_pkg::seq_t  seq_i,
  input  logic             seq_empty_i,
  output logic             seq_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output utf8e_pkg::out_t  out_o
);

  utf8e_pkg::seq_t                 cur_q, cur_d;
  logic                            valid_q, valid_d;
  logic [utf8e_pkg::ByteCntW-1:0]  idx_q, idx_d;
  logic                            last_byte, done;

  assign empty_o         = !valid_q;
  assign last_byte       = idx_q == cur_q.cnt - 1'b1;
  assign out_o.out_byte  = cur_q.bytes[idx_q];
  assign out_o.run_last  = last_byte;
  assign done            = !valid_q || (pop_i && last_byte);
  assign seq_pop_o       = done && !seq_empty_i;

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (done) begin
      // Load the next sequence in the same cycle the last byte leaves.
      valid_d = !seq_empty_i;
      cur_d   = seq_i;
      idx_d   = '0;
    end else if (pop_i) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

`include "utf16_to_utf8_encoder_top_assert.svh"

  `U8E_ASSERT(a_idx_in_seq, !valid_q || (cur_q.cnt != '0 && idx_q < cur_q.cnt), "byte index outside sequence")

endmodule

@@ design/utf16_to_utf8_encoder_top.sv @@
// UTF-16 to UTF-8 encoder.
// Input queue: drive in_data_i (code_unit, string_last) with push_i; the code
// unit is taken on a clock edge where push_i is high and full_o is low.
// Output queue: while empty_o is low, out_data_o holds the oldest UTF-8 byte;
// pop_i on such an edge consumes it. run_last marks the final byte that one
// code unit caused. A high surrogate that is not the last unit of a string
// causes no byte and is held until the next unit.
// With the back end idle, a taken unit is written into the queue, then loaded
// into the serializer, where its first byte is visible and can be popped.
// Throughput: one code unit per cycle is taken while full_o is low, and one
// byte per cycle is delivered while pop_i is high and empty_o is low; one
// code unit yields 0 to 6 bytes, which the serializer sends out in order.
// A four-entry queue between classifier and serializer absorbs bursts.
// When the receiver stops popping, the queue fills and full_o rises; no byte
// is lost. Reset clears the held surrogate and empties both queues.
module utf16_to_utf8_encoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8e_pkg::in_t   in_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output utf8e_pkg::out_t  out_data_o
);

  logic            accept;
  logic            seq_push, seq_pop, seq_empty;
  utf8e_pkg::seq_t seq_w, seq_r;

  assign accept = push_i && !full_o;

  utf8e_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i   (accept),
    .item_i     (in_data_i),
    .seq_push_o (seq_push),
    .seq_o      (seq_w)
  );

  utf8e_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (seq_push),
    .wdata_i (seq_w),
    .full_o  (full_o),
    .pop_i   (seq_pop),
    .rdata_o (seq_r),
    .empty_o (seq_empty)
  );

  utf8e_back u_back (
    .clk_i,
    .rst_ni,
    .seq_i       (seq_r),
    .seq_empty_i (seq_empty),
    .seq_pop_o   (seq_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_data_o)
  );

endmodule

@@ sim/utf8_stream_check.sv @@
module utf8_stream_check (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utf8e_pkg::in_t  in_data_i,
  input  logic            full_i,
  input  logic            pop_i,
  input  logic            empty_i,
  input  utf8e_pkg::out_t out_data_i,
  output int              errors_o,
  output int              pending_o,
  output int              bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxLines = 30;

  utf8e_pkg::out_t utf8_due[$];
  logic [9:0]      held_bits = '0;
  logic            held_ok   = 1'b0;
  int              bytes_seen = 0;

  task automatic report_mismatch(string what, logic [8:0] got, logic [8:0] want);
    if (errors_o < MaxLines) begin
      $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
    end
    errors_o++;
  endtask

  function automatic void append_byte(logic [7:0] v);
    utf8e_pkg::out_t b;
    b.out_byte = v;
    b.run_last = 1'b0;
    utf8_due.insert(utf8_due.size(), b);
  endfunction

  function automatic void append_scalar(logic [20:0] c);
    if (c < 21'h80) begin
      append_byte(c[7:0]);
    end else if (c < 21'h800) begin
      append_byte({3'b110, c[10:6]});
      append_byte({2'b10, c[5:0]});
    end else if (c < 21'h10000) begin
      append_byte({4'b1110, c[15:12]});
      append_byte({2'b10, c[11:6]});
      append_byte({2'b10, c[5:0]});
    end else begin
      append_byte({5'b11110, c[20:18]});
      append_byte({2'b10, c[17:12]});
      append_byte({2'b10, c[11:6]});
      append_byte({2'b10, c[5:0]});
    end
  endfunction

  // Work out the bytes that one accepted code unit causes.
  task automatic predict_unit(utf8e_pkg::in_t unit_in);
    int              n_before;
    logic            is_high;
    logic            is_low;
    logic            paired;
    utf8e_pkg::out_t tail_byte;
    n_before = utf8_due.size();
    is_high  = (unit_in.code_unit[15:10] == utf8e_pkg::HighSurrTag);
    is_low   = (unit_in.code_unit[15:10] == utf8e_pkg::LowSurrTag);
    paired   = 1'b0;
    if (held_ok) begin
      held_ok = 1'b0;
      if (is_low) begin
        append_scalar(21'h10000 + {held_bits, unit_in.code_unit[9:0]});
        paired = 1'b1;
      end else begin
        // flush the held high surrogate on its own
        append_scalar({5'b0, utf8e_pkg::HighSurrTag, held_bits});
      end
      held_bits = '0;
    end
    if (!paired) begin
      if (is_high && !unit_in.string_last) begin
        held_bits = unit_in.code_unit[9:0];
        held_ok   = 1'b1;
      end else begin
        append_scalar({5'b0, unit_in.code_unit});
      end
    end
    if (utf8_due.size() > n_before) begin
      tail_byte = utf8_due.pop_back();
      tail_byte.run_last = 1'b1;
      utf8_due.insert(utf8_due.size(), tail_byte);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    utf8e_pkg::out_t want;
    if (!rst_ni) begin
      utf8_due.delete();
      held_ok   = 1'b0;
      held_bits = '0;
      pending_o <= 0;
    end else begin
      // compare first: a unit taken at this edge cannot show up yet
      if (pop_i && !empty_i) begin
        bytes_seen++;
        if (utf8_due.size() == 0) begin
          report_mismatch("byte with nothing due", out_data_i, '0);
        end else begin
          want = utf8_due.pop_front();
          if (out_data_i.out_byte != want.out_byte) begin
            report_mismatch("out_byte", out_data_i, want);
          end
          if (out_data_i.run_last != want.run_last) begin
            report_mismatch("run_last", out_data_i, want);
          end
        end
      end
      if (push_i && !full_i) begin
        predict_unit(in_data_i);
      end
      pending_o <= utf8_due.size();
      bytes_o   <= bytes_seen;
    end
  end

endmodule

@@ sim/utf16_to_utf8_encoder_top_test.sv @@
module utf16_to_utf8_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned TailCycles = 16;

  logic            clk_i;
  logic            rst_ni     = 1'b0;
  logic            push_i     = 1'b0;
  utf8e_pkg::in_t  in_data_i  = '0;
  logic            full_o;
  logic            pop_i      = 1'b0;
  logic            empty_o;
  utf8e_pkg::out_t out_data_o;

  int errors;
  int pending;
  int bytes_seen;
  int units_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_pct   = 0;
  int mode_left   = 0;

  utf16_to_utf8_encoder_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_data_i  (in_data_i),
    .full_o     (full_o),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_data_o (out_data_o)
  );

  utf8_stream_check stream_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_data_i  (in_data_i),
    .full_i     (full_o),
    .pop_i      (pop_i),
    .empty_i    (empty_o),
    .out_data_i (out_data_o),
    .errors_o   (errors),
    .pending_o  (pending),
    .bytes_o    (bytes_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: switch between stall profiles, from free-running to mostly stalled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i     <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      mode_left--;
      pop_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("[utf16_to_utf8_encoder_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold the code unit until the encoder takes it; insert a gap between bursts.
  task automatic send_unit(logic [15:0] cu, logic last);
    if (burst_left == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    push_i    <= 1'b1;
    in_data_i <= '{code_unit: cu, string_last: last};
    do @(posedge clk_i); while (full_o);
    units_sent++;
  endtask

  task automatic drain_results();
    push_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_text(int unsigned n_units);
    int unsigned k;
    logic        last;
    k = 0;
    while (k < n_units) begin
      last = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_unit({utf8e_pkg::HighSurrTag, 10'($urandom_range(0, 1023))}, 1'b0);
          send_unit({utf8e_pkg::LowSurrTag, 10'($urandom_range(0, 1023))}, last);
          k += 2;
        end
        4: begin
          send_unit({utf8e_pkg::HighSurrTag, 10'($urandom_range(0, 1023))}, last);
          k++;
        end
        5: begin
          send_unit({utf8e_pkg::LowSurrTag, 10'($urandom_range(0, 1023))}, last);
          k++;
        end
        6: begin
          send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
          k++;
        end
        7: begin
          send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
          k++;
        end
        default: begin
          send_unit(16'($urandom), last);
          k++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // band edges of the 1, 2 and 3 byte forms
    send_unit(16'h0000, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    // lowest and highest surrogate pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // high surrogate as the last unit goes out at once
    send_unit(16'hD800, 1'b1);
    // lone low surrogates
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    // held high surrogate flushed by a plain unit
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'h0041, 1'b0);
    // held high followed by another high, then a pair that ends the string
    send_unit(16'hD900, 1'b0);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hDC00, 1'b1);
    // six bytes from one unit
    send_unit(16'hDABC, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD8FF, 1'b0);
    send_unit(16'hDB00, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h07FF, 1'b1);
    drain_results();

    send_random_text(120);
    drain_results();
    send_random_text(120);

    push_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d code units: band edges, surrogate pairs, lone and held surrogates,",
             units_sent);
    $display("string ends; %0d UTF-8 bytes compared under random stalls on both sides",
             bytes_seen);
    if (errors == 0) begin
      $display("[utf16_to_utf8_encoder_top] OK");
    end else begin
      $display("[utf16_to_utf8_encoder_top] ERROR");
    end
    $finish;
  end

endmodule
